/* rtl/cac_pkg.sv */
// ----------------------------------------------------------------------------
// cac_pkg
// Shared widths, codes and the request record of the admission check.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned WORDS_DEF   = 4;

  localparam int unsigned BIT_COUNT   = 64;
  localparam int unsigned WORD_W      = BIT_COUNT;
  localparam int unsigned LBIT_W      = $clog2(BIT_COUNT);
  localparam int unsigned ID_W        = 32;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned AMT_W       = 32;
  localparam int unsigned TC_W        = 5;
  localparam int unsigned EIDX_W      = 4;
  localparam int unsigned WIDX_W      = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned FIELD_W     = 8;
  localparam int unsigned BUILD_LO_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY_HDR  = 2'd0,
    KIND_ENTRY_WORD = 2'd1,
    KIND_REQ_HDR    = 2'd2,
    KIND_REQ_WORD   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_ATTACH   = 3'd1,
    ST_MISSING     = 3'd2,
    ST_OVER_BUDGET = 3'd3,
    ST_WRONG_FW    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_COUNT = 2'd0,
    CFG_BUILD_HI    = 2'd1,
    CFG_BUILD_MID   = 2'd2,
    CFG_BUILD_LO    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    kind_e               kind;
    logic [EIDX_W-1:0]   entry_index;
    logic [WIDX_W-1:0]   word_index;
    logic [ID_W-1:0]     target_id;
    logic [CNT_W-1:0]    word_count;
    logic [AMT_W-1:0]    amount;
    logic [WORD_W-1:0]   bitmap_word;
    logic                build_fail;
    logic                last_word;
  } cmd_t;

endpackage

/* rtl/cac_front.sv */
// ----------------------------------------------------------------------------
// cac_front
// Configuration registers, request intake, filtering and classification.
// ----------------------------------------------------------------------------
module cac_front
  import cac_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned WORDS   = WORDS_DEF,
  localparam int unsigned SLW    = $clog2(ENTRIES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [WORD_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [EIDX_W-1:0]     entry_index_i,
  input  logic [WIDX_W-1:0]     word_index_i,
  input  logic [ID_W-1:0]       target_id_i,
  input  logic [CNT_W-1:0]      word_count_i,
  input  logic [AMT_W-1:0]      max_budget_i,
  input  logic [AMT_W-1:0]      charge_i,
  input  logic [WORD_W-1:0]     bitmap_word_i,
  input  logic                  bind_build_i,
  input  logic [WORD_W-1:0]     req_build_hi_i,
  input  logic [WORD_W-1:0]     req_build_mid_i,
  input  logic [BUILD_LO_W-1:0] req_build_lo_i,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  output logic [SLW-1:0]        search_len_o
);

  localparam int unsigned LAST_WORD = ((WORDS < 4) ? WORDS : 4) - 1;

  logic [TC_W-1:0]       table_count_q, table_count_d;
  logic [WORD_W-1:0]     build_hi_q, build_hi_d;
  logic [WORD_W-1:0]     build_mid_q, build_mid_d;
  logic [BUILD_LO_W-1:0] build_lo_q, build_lo_d;
  logic                  entry_ok;
  logic                  word_ok;
  logic                  keep;
  kind_e                 kind;

  always_comb begin
    table_count_d = table_count_q;
    build_hi_d    = build_hi_q;
    build_mid_d   = build_mid_q;
    build_lo_d    = build_lo_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TABLE_COUNT: table_count_d = cfg_data_i[TC_W-1:0];
        CFG_BUILD_HI:    build_hi_d    = cfg_data_i;
        CFG_BUILD_MID:   build_mid_d   = cfg_data_i;
        CFG_BUILD_LO:    build_lo_d    = cfg_data_i[BUILD_LO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count_q <= '0;
      build_hi_q    <= '0;
      build_mid_q   <= '0;
      build_lo_q    <= '0;
    end else begin
      table_count_q <= table_count_d;
      build_hi_q    <= build_hi_d;
      build_mid_q   <= build_mid_d;
      build_lo_q    <= build_lo_d;
    end
  end

  assign search_len_o = (32'(table_count_q) < ENTRIES) ? SLW'(table_count_q) : SLW'(ENTRIES);

  assign kind     = kind_e'(kind_i);
  assign entry_ok = 32'(entry_index_i) < ENTRIES;
  assign word_ok  = 32'(word_index_i) < WORDS;

  // out of range slots and words are dropped here
  always_comb begin
    case (kind)
      KIND_ENTRY_HDR:  keep = entry_ok;
      KIND_ENTRY_WORD: keep = entry_ok && word_ok;
      KIND_REQ_HDR:    keep = 1'b1;
      KIND_REQ_WORD:   keep = word_ok;
      default:         keep = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

  always_comb begin
    cmd_o.kind        = kind;
    cmd_o.entry_index = entry_index_i;
    cmd_o.word_index  = word_index_i;
    cmd_o.target_id   = target_id_i;
    cmd_o.word_count  = (32'(word_count_i) > WORDS) ? CNT_W'(WORDS) : word_count_i;
    cmd_o.amount      = (kind == KIND_REQ_HDR) ? charge_i : max_budget_i;
    cmd_o.bitmap_word = bitmap_word_i;
    cmd_o.build_fail  = bind_build_i && ((req_build_hi_i != build_hi_q) ||
                                         (req_build_mid_i != build_mid_q) ||
                                         (req_build_lo_i != build_lo_q));
    cmd_o.last_word   = word_index_i == WIDX_W'(LAST_WORD);
  end

endmodule

/* rtl/cac_queue.sv */
// ----------------------------------------------------------------------------
// cac_queue
// Short request queue between intake and execution.
// ----------------------------------------------------------------------------
module cac_queue
  import cac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = count_q == CW'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QUEUE_DEPTH) else $error("queue count out of range");

endmodule

/* rtl/cac_back.sv */
// ----------------------------------------------------------------------------
// cac_back
// Table storage, attach search, field check, budget check and result register.
// ----------------------------------------------------------------------------
module cac_back
  import cac_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned WORDS   = WORDS_DEF,
  localparam int unsigned SLW    = $clog2(ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                avail_i,
  output logic                pop_o,
  input  logic [SLW-1:0]      search_len_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIELD_W-1:0]  missing_field_o
);

  localparam int unsigned EAW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned BDEPTH = ENTRIES * WORDS;
  localparam int unsigned BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int unsigned GRP    = 8;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic [AMT_W-1:0] budget;
  } hdr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WORD_CHK,
    S_WORD_ENC,
    S_EMIT
  } state_e;

  function automatic logic [LBIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [GRP-1:0] grp;
    logic [GRP-1:0] sel;
    logic [2:0]     g;
    logic [2:0]     b;
    logic           hit_g;
    logic           hit_b;
    for (int i = 0; i < GRP; i++) begin
      grp[i] = |v[i*GRP +: GRP];
    end
    g     = '0;
    hit_g = 1'b0;
    for (int i = 0; i < GRP; i++) begin
      if (!hit_g && grp[i]) begin
        g     = 3'(i);
        hit_g = 1'b1;
      end
    end
    sel   = v[g*GRP +: GRP];
    b     = '0;
    hit_b = 1'b0;
    for (int i = 0; i < GRP; i++) begin
      if (!hit_b && sel[i]) begin
        b     = 3'(i);
        hit_b = 1'b1;
      end
    end
    return {g, b};
  endfunction

  // table storage
  hdr_t              hdr_mem [ENTRIES];
  logic [WORD_W-1:0] bit_mem [BDEPTH];
  hdr_t              hdr_rdata_q;
  logic [WORD_W-1:0] bit_rdata_q;

  logic              hdr_we, hdr_re, bit_we, bit_re;
  logic [EAW-1:0]    hdr_waddr, hdr_raddr;
  logic [BAW-1:0]    bit_waddr, bit_raddr;
  hdr_t              hdr_wdata;

  state_e             state_q, state_d;
  logic [SLW-1:0]     iss_q, iss_d;
  logic               chk_vld_q, chk_vld_d;
  logic [EAW-1:0]     chk_idx_q, chk_idx_d;
  logic [ID_W-1:0]    want_id_q, want_id_d;
  status_e            pend_status_q, pend_status_d;
  logic [EAW-1:0]     match_q, match_d;
  logic [AMT_W-1:0]   pend_cost_q, pend_cost_d;
  logic [FIELD_W-1:0] first_missing_q, first_missing_d;
  logic [WIDX_W-1:0]  widx_q, widx_d;
  logic               last_q, last_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [WORD_W-1:0]  missing_q, missing_d;
  logic [AMT_W-1:0]   budget_q, budget_d;
  status_e            res_status_q, res_status_d;
  logic [FIELD_W-1:0] res_field_q, res_field_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [FIELD_W-1:0] out_field_q, out_field_d;

  status_e            enc_status;
  logic [FIELD_W-1:0] enc_field;
  logic               issue;

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rdata_q <= hdr_mem[hdr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bit_we) begin
      bit_mem[bit_waddr] <= cmd_i.bitmap_word;
    end
    if (bit_re) begin
      bit_rdata_q <= bit_mem[bit_raddr];
    end
  end

  assign hdr_waddr = EAW'(cmd_i.entry_index);
  assign bit_waddr = BAW'(32'(cmd_i.entry_index) * WORDS + 32'(cmd_i.word_index));
  assign bit_raddr = BAW'(32'(match_q) * WORDS + 32'(cmd_i.word_index));
  assign hdr_wdata = '{id: cmd_i.target_id, cnt: cmd_i.word_count, budget: cmd_i.amount};
  assign issue     = iss_q < search_len_i;

  // first missing field of the current word
  always_comb begin
    enc_status = pend_status_q;
    enc_field  = first_missing_q;
    if (missing_q != '0) begin
      enc_status = ST_MISSING;
      enc_field  = {widx_q, lowest_bit(missing_q)};
    end
  end

  always_comb begin
    state_d         = state_q;
    iss_d           = iss_q;
    chk_vld_d       = chk_vld_q;
    chk_idx_d       = chk_idx_q;
    want_id_d       = want_id_q;
    pend_status_d   = pend_status_q;
    match_d         = match_q;
    pend_cost_d     = pend_cost_q;
    first_missing_d = first_missing_q;
    widx_d          = widx_q;
    last_d          = last_q;
    word_d          = word_q;
    missing_d       = missing_q;
    budget_d        = budget_q;
    res_status_d    = res_status_q;
    res_field_d     = res_field_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_status_d    = out_status_q;
    out_field_d     = out_field_q;
    pop_o           = 1'b0;
    hdr_we          = 1'b0;
    hdr_re          = 1'b0;
    bit_we          = 1'b0;
    bit_re          = 1'b0;
    hdr_raddr       = match_q;

    case (state_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_ENTRY_HDR:  hdr_we = 1'b1;
            KIND_ENTRY_WORD: bit_we = 1'b1;
            KIND_REQ_HDR: begin
              pend_cost_d     = cmd_i.amount;
              first_missing_d = '0;
              match_d         = '0;
              want_id_d       = cmd_i.target_id;
              if (cmd_i.build_fail) begin
                pend_status_d = ST_WRONG_FW;
              end else begin
                iss_d     = '0;
                chk_vld_d = 1'b0;
                state_d   = S_SEARCH;
              end
            end
            KIND_REQ_WORD: begin
              widx_d = cmd_i.word_index;
              last_d = cmd_i.last_word;
              word_d = cmd_i.bitmap_word;
              if (pend_status_q == ST_OK) begin
                hdr_re  = 1'b1;
                bit_re  = 1'b1;
                state_d = S_WORD_CHK;
              end else if (cmd_i.last_word) begin
                res_status_d = pend_status_q;
                res_field_d  = (pend_status_q == ST_MISSING) ? first_missing_q : '0;
                state_d      = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      // one slot read per cycle, compared in the next cycle
      S_SEARCH: begin
        if (chk_vld_q && (hdr_rdata_q.id == want_id_q)) begin
          match_d       = chk_idx_q;
          pend_status_d = ST_OK;
          state_d       = S_IDLE;
        end else if (!issue && !chk_vld_q) begin
          pend_status_d = ST_NO_ATTACH;
          state_d       = S_IDLE;
        end else if (issue) begin
          hdr_re    = 1'b1;
          hdr_raddr = EAW'(iss_q);
          iss_d     = SLW'(iss_q + 1'b1);
          chk_vld_d = 1'b1;
          chk_idx_d = EAW'(iss_q);
        end else begin
          chk_vld_d = 1'b0;
        end
      end

      S_WORD_CHK: begin
        missing_d = (CNT_W'(widx_q) < hdr_rdata_q.cnt) ? (word_q & ~bit_rdata_q) : word_q;
        budget_d  = hdr_rdata_q.budget;
        state_d   = S_WORD_ENC;
      end

      S_WORD_ENC: begin
        pend_status_d   = enc_status;
        first_missing_d = enc_field;
        if (last_q) begin
          res_status_d = ((enc_status == ST_OK) && (pend_cost_q > budget_q)) ?
                         ST_OVER_BUDGET : enc_status;
          res_field_d  = (enc_status == ST_MISSING) ? enc_field : '0;
          state_d      = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_field_d  = res_field_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      iss_q           <= '0;
      chk_vld_q       <= 1'b0;
      chk_idx_q       <= '0;
      want_id_q       <= '0;
      pend_status_q   <= ST_OK;
      match_q         <= '0;
      pend_cost_q     <= '0;
      first_missing_q <= '0;
      widx_q          <= '0;
      last_q          <= 1'b0;
      word_q          <= '0;
      missing_q       <= '0;
      budget_q        <= '0;
      res_status_q    <= ST_OK;
      res_field_q     <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= ST_OK;
      out_field_q     <= '0;
    end else begin
      state_q         <= state_d;
      iss_q           <= iss_d;
      chk_vld_q       <= chk_vld_d;
      chk_idx_q       <= chk_idx_d;
      want_id_q       <= want_id_d;
      pend_status_q   <= pend_status_d;
      match_q         <= match_d;
      pend_cost_q     <= pend_cost_d;
      first_missing_q <= first_missing_d;
      widx_q          <= widx_d;
      last_q          <= last_d;
      word_q          <= word_d;
      missing_q       <= missing_d;
      budget_q        <= budget_d;
      res_status_q    <= res_status_d;
      res_field_q     <= res_field_d;
      out_valid_q     <= out_valid_d;
      out_status_q    <= out_status_d;
      out_field_q     <= out_field_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign missing_field_o = out_field_q;

  a_field_only_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_MISSING) |-> missing_field_o == '0)
    else $error("missing field set without missing status");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> iss_q <= search_len_i)
    else $error("search ran past table count");

  a_pending_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_status_q != ST_OVER_BUDGET)
    else $error("budget status held as pending");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("result not presented");

endmodule

/* rtl/capability_admission_check_core.sv */
// path: a last request word goes from the queue through the table read, word check,
//   encode and emit states to the output register; a last word of a failed request
//   goes straight to emit. The back end pops the queue only while idle; a request header
//   without a build failure first searches up to min(table_count, ENTRIES) slots
// reset: configuration and request state clear to zero, the table is undefined until written
// ----------------------------------------------------------------------------
// capability_admission_check_core
// Attach point table with admission check of build id, attach id, fields
// and cost budget.
// ----------------------------------------------------------------------------
module capability_admission_check_core
  import cac_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned WORDS   = WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [WORD_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [EIDX_W-1:0]     entry_index_i,
  input  logic [WIDX_W-1:0]     word_index_i,
  input  logic [ID_W-1:0]       target_id_i,
  input  logic [CNT_W-1:0]      word_count_i,
  input  logic [AMT_W-1:0]      max_budget_i,
  input  logic [AMT_W-1:0]      charge_i,
  input  logic [WORD_W-1:0]     bitmap_word_i,
  input  logic                  bind_build_i,
  input  logic [WORD_W-1:0]     req_build_hi_i,
  input  logic [WORD_W-1:0]     req_build_mid_i,
  input  logic [BUILD_LO_W-1:0] req_build_lo_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [FIELD_W-1:0]    missing_field_o
);

  localparam int unsigned SLW = $clog2(ENTRIES + 1);

  cmd_t           push_cmd;
  cmd_t           head_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  logic [SLW-1:0] search_len;

  cac_front #(
    .ENTRIES (ENTRIES),
    .WORDS   (WORDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .entry_index_i   (entry_index_i),
    .word_index_i    (word_index_i),
    .target_id_i     (target_id_i),
    .word_count_i    (word_count_i),
    .max_budget_i    (max_budget_i),
    .charge_i        (charge_i),
    .bitmap_word_i   (bitmap_word_i),
    .bind_build_i    (bind_build_i),
    .req_build_hi_i  (req_build_hi_i),
    .req_build_mid_i (req_build_mid_i),
    .req_build_lo_i  (req_build_lo_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .search_len_o    (search_len)
  );

  cac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  cac_back #(
    .ENTRIES (ENTRIES),
    .WORDS   (WORDS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head_cmd),
    .avail_i         (!empty),
    .pop_o           (pop),
    .search_len_i    (search_len),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .missing_field_o (missing_field_o)
  );

endmodule

/* test/capability_admission_check_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capability_admission_check_core_tb
// Self-checking bench for the admission check. Every request taken by the
// block updates a local copy of the attach table, the registers and the
// pending admission; each status that comes out is compared in order with
// the verdict worked out from that copy. The table is loaded in full
// first, then directed cases, register extremes, a long output stall and
// three phases of random traffic with different idling.
// ----------------------------------------------------------------------------
module capability_admission_check_core_tb
  import cac_pkg::*;
();

  localparam int unsigned LAST_WIDX     = ((WORDS_DEF < 4) ? WORDS_DEF : 4) - 1;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct {
    kind_e                 kind;
    logic [EIDX_W-1:0]     entry_index;
    logic [WIDX_W-1:0]     word_index;
    logic [ID_W-1:0]       target_id;
    logic [CNT_W-1:0]      word_count;
    logic [AMT_W-1:0]      max_budget;
    logic [AMT_W-1:0]      charge;
    logic [WORD_W-1:0]     bitmap_word;
    logic                  bind_build;
    logic [WORD_W-1:0]     build_hi;
    logic [WORD_W-1:0]     build_mid;
    logic [BUILD_LO_W-1:0] build_lo;
  } admit_req_t;

  typedef struct {
    status_e              status;
    logic [FIELD_W-1:0]   field;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [WORD_W-1:0]     cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i = '0;
  logic [EIDX_W-1:0]     entry_index_i = '0;
  logic [WIDX_W-1:0]     word_index_i = '0;
  logic [ID_W-1:0]       target_id_i = '0;
  logic [CNT_W-1:0]      word_count_i = '0;
  logic [AMT_W-1:0]      max_budget_i = '0;
  logic [AMT_W-1:0]      charge_i = '0;
  logic [WORD_W-1:0]     bitmap_word_i = '0;
  logic                  bind_build_i = 1'b0;
  logic [WORD_W-1:0]     req_build_hi_i = '0;
  logic [WORD_W-1:0]     req_build_mid_i = '0;
  logic [BUILD_LO_W-1:0] req_build_lo_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [FIELD_W-1:0]    missing_field_o;

  // local copy of the block state
  logic [ID_W-1:0]       tbl_id     [ENTRIES_DEF];
  logic [CNT_W-1:0]      tbl_words  [ENTRIES_DEF];
  logic [AMT_W-1:0]      tbl_budget [ENTRIES_DEF];
  logic [WORD_W-1:0]     tbl_map    [ENTRIES_DEF][WORDS_DEF];
  logic [TC_W-1:0]       cur_table_count = '0;
  logic [WORD_W-1:0]     cur_build_hi = '0;
  logic [WORD_W-1:0]     cur_build_mid = '0;
  logic [BUILD_LO_W-1:0] cur_build_lo = '0;
  status_e               req_state = ST_OK;
  logic [EIDX_W-1:0]     req_slot = '0;
  logic [AMT_W-1:0]      req_cost = '0;
  logic [FIELD_W-1:0]    req_first_bit = '0;

  verdict_t    expected_verdicts[$];
  int unsigned status_tally[5];
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 20;
  int unsigned rx_stall_pct = 20;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;

  capability_admission_check_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .entry_index_i   (entry_index_i),
    .word_index_i    (word_index_i),
    .target_id_i     (target_id_i),
    .word_count_i    (word_count_i),
    .max_budget_i    (max_budget_i),
    .charge_i        (charge_i),
    .bitmap_word_i   (bitmap_word_i),
    .bind_build_i    (bind_build_i),
    .req_build_hi_i  (req_build_hi_i),
    .req_build_mid_i (req_build_mid_i),
    .req_build_lo_i  (req_build_lo_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .missing_field_o (missing_field_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic admit_req_t random_req();
    admit_req_t r;
    r.kind        = kind_e'($urandom_range(3));
    r.entry_index = EIDX_W'($urandom_range(ENTRIES_DEF - 1));
    r.word_index  = WIDX_W'($urandom_range(3));
    r.target_id   = $urandom;
    r.word_count  = CNT_W'($urandom_range(7));
    r.max_budget  = $urandom;
    r.charge      = $urandom;
    r.bitmap_word = rand_word();
    r.bind_build  = 1'($urandom_range(1));
    r.build_hi    = rand_word();
    r.build_mid   = rand_word();
    r.build_lo    = $urandom;
    return r;
  endfunction

  function automatic void predict_admission(input admit_req_t r);
    int unsigned n;
    int unsigned i;
    int unsigned b;
    int unsigned pos;
    logic [WORD_W-1:0] missing;
    logic hit;
    verdict_t v;
    case (r.kind)
      KIND_ENTRY_HDR: begin
        if (r.entry_index < ENTRIES_DEF) begin
          tbl_id[r.entry_index]     = r.target_id;
          tbl_words[r.entry_index]  = (r.word_count > WORDS_DEF) ? CNT_W'(WORDS_DEF)
                                                                 : r.word_count;
          tbl_budget[r.entry_index] = r.max_budget;
        end
      end
      KIND_ENTRY_WORD: begin
        if (r.entry_index < ENTRIES_DEF && r.word_index < WORDS_DEF)
          tbl_map[r.entry_index][r.word_index] = r.bitmap_word;
      end
      KIND_REQ_HDR: begin
        req_first_bit = '0;
        req_cost      = r.charge;
        req_slot      = '0;
        if (r.bind_build && ({r.build_hi, r.build_mid, r.build_lo} !=
                             {cur_build_hi, cur_build_mid, cur_build_lo})) begin
          req_state = ST_WRONG_FW;
        end else begin
          n   = (cur_table_count < ENTRIES_DEF) ? cur_table_count : ENTRIES_DEF;
          hit = 1'b0;
          for (i = 0; i < n; i++) begin
            if (!hit && tbl_id[i] == r.target_id) begin
              hit      = 1'b1;
              req_slot = EIDX_W'(i);
            end
          end
          req_state = hit ? ST_OK : ST_NO_ATTACH;
        end
      end
      default: begin
        if (r.word_index < WORDS_DEF) begin
          if (req_state == ST_OK) begin
            missing = r.bitmap_word;
            if (r.word_index < tbl_words[req_slot])
              missing = missing & ~tbl_map[req_slot][r.word_index];
            if (missing != '0) begin
              b = 0;
              while (!missing[b]) b++;
              pos           = r.word_index * BIT_COUNT + b;
              req_state     = ST_MISSING;
              req_first_bit = pos[FIELD_W-1:0];
            end
          end
          if (r.word_index == LAST_WIDX) begin
            v.status = req_state;
            if (v.status == ST_OK && req_cost > tbl_budget[req_slot])
              v.status = ST_OVER_BUDGET;
            v.field = (v.status == ST_MISSING) ? req_first_bit : '0;
            status_tally[int'(v.status)]++;
            expected_verdicts.push_back(v);
          end
        end
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input admit_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i          = r.kind;
    entry_index_i   = r.entry_index;
    word_index_i    = r.word_index;
    target_id_i     = r.target_id;
    word_count_i    = r.word_count;
    max_budget_i    = r.max_budget;
    charge_i        = r.charge;
    bitmap_word_i   = r.bitmap_word;
    bind_build_i    = r.bind_build;
    req_build_hi_i  = r.build_hi;
    req_build_mid_i = r.build_mid;
    req_build_lo_i  = r.build_lo;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_admission(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_entry_header(input int unsigned slot, input logic [ID_W-1:0] id,
                                   input int unsigned count, input logic [AMT_W-1:0] budget);
    admit_req_t r;
    r             = random_req();
    r.kind        = KIND_ENTRY_HDR;
    r.entry_index = EIDX_W'(slot);
    r.target_id   = id;
    r.word_count  = CNT_W'(count);
    r.max_budget  = budget;
    send_item(r);
  endtask

  task automatic send_entry_word(input int unsigned slot, input int unsigned widx,
                                 input logic [WORD_W-1:0] word);
    admit_req_t r;
    r             = random_req();
    r.kind        = KIND_ENTRY_WORD;
    r.entry_index = EIDX_W'(slot);
    r.word_index  = WIDX_W'(widx);
    r.bitmap_word = word;
    send_item(r);
  endtask

  task automatic send_req_header(input logic [ID_W-1:0] id, input logic [AMT_W-1:0] cost,
                                 input logic bind_fw, input logic [WORD_W-1:0] hi,
                                 input logic [WORD_W-1:0] mid,
                                 input logic [BUILD_LO_W-1:0] lo);
    admit_req_t r;
    r            = random_req();
    r.kind       = KIND_REQ_HDR;
    r.target_id  = id;
    r.charge     = cost;
    r.bind_build = bind_fw;
    r.build_hi   = hi;
    r.build_mid  = mid;
    r.build_lo   = lo;
    send_item(r);
  endtask

  task automatic send_req_word(input int unsigned widx, input logic [WORD_W-1:0] word);
    admit_req_t r;
    r             = random_req();
    r.kind        = KIND_REQ_WORD;
    r.word_index  = WIDX_W'(widx);
    r.bitmap_word = word;
    send_item(r);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WORD_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    case (idx)
      CFG_TABLE_COUNT: cur_table_count = data[TC_W-1:0];
      CFG_BUILD_HI:    cur_build_hi    = data;
      CFG_BUILD_MID:   cur_build_mid   = data;
      default:         cur_build_lo    = data[BUILD_LO_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_registers(input int unsigned count, input logic [WORD_W-1:0] hi,
                                   input logic [WORD_W-1:0] mid,
                                   input logic [BUILD_LO_W-1:0] lo);
    logic [WORD_W-1:0] data;
    data           = rand_word();
    data[TC_W-1:0] = TC_W'(count);
    write_reg(CFG_TABLE_COUNT, data);
    write_reg(CFG_BUILD_HI, hi);
    write_reg(CFG_BUILD_MID, mid);
    data                 = rand_word();
    data[BUILD_LO_W-1:0] = lo;
    write_reg(CFG_BUILD_LO, data);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned n;
    int unsigned k;
    int unsigned w;
    int unsigned pick;
    logic [AMT_W-1:0] cost;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] mid;
    logic [BUILD_LO_W-1:0] lo;
    logic [WORD_W-1:0] wanted;
    logic [ID_W-1:0] id;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      pick = $urandom_range(99);
      n    = (cur_table_count < ENTRIES_DEF) ? cur_table_count : ENTRIES_DEF;
      k    = (n == 0) ? $urandom_range(ENTRIES_DEF - 1) : $urandom_range(n - 1);
      id   = ($urandom_range(3) != 0) ? tbl_id[k] : $urandom;
      if (pick < 70) begin
        case ($urandom_range(3))
          0:       cost = tbl_budget[k];
          1:       cost = tbl_budget[k] + 1;
          2:       cost = tbl_budget[k] - 1;
          default: cost = $urandom;
        endcase
        hi  = cur_build_hi;
        mid = cur_build_mid;
        lo  = cur_build_lo;
        if ($urandom_range(9) < 3) begin
          case ($urandom_range(2))
            0:       hi[$urandom_range(63)] = ~hi[$urandom_range(63)];
            1:       mid = mid ^ (64'd1 << $urandom_range(63));
            default: lo = lo ^ (32'd1 << $urandom_range(31));
          endcase
        end
        send_req_header(id, cost, 1'($urandom_range(1)), hi, mid, lo);
        for (w = 0; w < WORDS_DEF; w++) begin
          wanted = (w < tbl_words[k]) ? (tbl_map[k][w] & rand_word()) : '0;
          if ($urandom_range(9) == 0) wanted = wanted | (64'd1 << $urandom_range(63));
          send_req_word(w, wanted);
        end
      end else if (pick < 80) begin
        if ($urandom_range(1) == 0)
          send_entry_header($urandom_range(ENTRIES_DEF - 1),
                            ($urandom_range(1) == 0) ? tbl_id[$urandom_range(15)] : id,
                            $urandom_range(7), $urandom);
        else
          send_entry_word($urandom_range(ENTRIES_DEF - 1), $urandom_range(WORDS_DEF - 1),
                          rand_word());
      end else if (pick < 90) begin
        // broken sequence: optional header, then up to three words in any order
        if ($urandom_range(1) == 0)
          send_req_header(id, $urandom, 1'b0, rand_word(), rand_word(), $urandom);
        repeat ($urandom_range(3)) begin
          w = $urandom_range(WORDS_DEF - 1);
          send_req_word(w, ($urandom_range(1) == 0) ? (tbl_map[k][w] & rand_word())
                                                    : rand_word());
        end
      end else begin
        send_item(random_req());
      end
    end
  endtask

  task automatic test_table_load();
    int unsigned i;
    int unsigned w;
    logic [ID_W-1:0] id;
    logic [AMT_W-1:0] budget;
    logic [WORD_W-1:0] word;
    for (i = 0; i < ENTRIES_DEF; i++) begin
      case (i)
        7:       id = tbl_id[2];
        14:      id = '0;
        15:      id = '1;
        default: id = 32'h0A00_0000 + i;
      endcase
      case (i)
        1, 7:    budget = '0;
        2:       budget = '1;
        4:       budget = 32'h0000_1000;
        default: budget = $urandom;
      endcase
      send_entry_header(i, id, i % 8, budget);
      for (w = 0; w < WORDS_DEF; w++) begin
        word = (i == 4) ? '1 : (i == 5) ? '0 : rand_word();
        send_entry_word(i, w, word);
      end
    end
  endtask

  task automatic test_directed_cases();
    // words with no header see the state left by reset
    send_req_word(LAST_WIDX, '0);
    send_req_word(LAST_WIDX, '1);
    send_req_word(LAST_WIDX, '0);
    // bound build that matches, all fields offered, cost equal to budget
    send_req_header(tbl_id[4], tbl_budget[4], 1'b1, cur_build_hi, cur_build_mid, cur_build_lo);
    send_req_word(0, '1);
    send_req_word(1, '1);
    send_req_word(2, '1);
    send_req_word(3, '1);
    // over budget by one
    send_req_header(tbl_id[4], tbl_budget[4] + 1, 1'b0, rand_word(), rand_word(), $urandom);
    send_req_word(LAST_WIDX, '0);
    // first missing field in arrival order, earlier words never sent
    send_req_header(tbl_id[5], '0, 1'b0, '0, '0, '0);
    send_req_word(2, 64'h80);
    send_req_word(3, 64'h1);
    // word at or above the published count, highest field position
    send_req_header(tbl_id[0], '0, 1'b0, '1, '1, '1);
    send_req_word(LAST_WIDX, 64'h8000_0000_0000_0000);
    // build mismatch in the low part only
    send_req_header(tbl_id[1], '0, 1'b1, cur_build_hi, cur_build_mid, ~cur_build_lo);
    send_req_word(LAST_WIDX, '1);
    // unknown attach id
    send_req_header(32'h5A5A_0001, '0, 1'b0, rand_word(), rand_word(), $urandom);
    send_req_word(LAST_WIDX, '1);
    // duplicate id resolves to the lower slot
    send_req_header(tbl_id[2], 32'd1, 1'b0, '0, '0, '0);
    send_req_word(LAST_WIDX, '0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    program_registers(0, '0, '0, '0);
    send_random_traffic(60);
    wait_idle();
    program_registers(31, '1, '1, '1);
    send_random_traffic(60);
  endtask

  task automatic test_backpressure();
    wait_idle();
    program_registers(ENTRIES_DEF, rand_word(), rand_word(), $urandom);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = HOLD_CYCLES;
    send_random_traffic(60);
    wait_idle();
  endtask

  task automatic test_idle_mix();
    program_registers(ENTRIES_DEF, rand_word(), rand_word(), $urandom);
    tx_idle_pct  = 7;
    rx_stall_pct = 85;
    send_random_traffic(500);
    wait_idle();
    program_registers($urandom_range(1, ENTRIES_DEF - 1), rand_word(), rand_word(), $urandom);
    tx_idle_pct  = 85;
    rx_stall_pct = 7;
    send_random_traffic(500);
    wait_idle();
    program_registers(ENTRIES_DEF, rand_word(), rand_word(), $urandom);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random_traffic(500);
    wait_idle();
  endtask

  // result side ready, with a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left != 0) begin
        out_ready_i = 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: status %0d missing_field %0d", status_o, missing_field_o);
        err_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          err_count++;
        end
        if (missing_field_o !== want.field) begin
          $error("missing_field mismatch: expected %0d, actual %0d", want.field,
                 missing_field_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    program_registers(ENTRIES_DEF, rand_word(), rand_word(), $urandom);
    test_table_load();
    test_directed_cases();
    test_register_extremes();
    test_backpressure();
    test_idle_mix();
    $display("sent %0d requests, checked %0d results", requests_sent, results_checked);
    $display("statuses: ok %0d, no attach %0d, missing %0d, over budget %0d, wrong fw %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
